// ===== rtl/pfs_pkg.sv =====
// Package with the widths and constants shared by the PCM frame statistics files.
`default_nettype none

package pfs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 16;
    localparam int CNT_W    = 32;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int ENERGY_W = 64;

    localparam logic signed [SAMPLE_W-1:0] CLIP_HIGH = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] CLIP_LOW  = 16'sh8000;
    localparam logic [PEAK_W-1:0]          PEAK_MAX  = 16'h8000;

endpackage

`default_nettype wire

// ===== rtl/pfs_in_if.sv =====
// Handshake interface that carries one PCM sample item into the block.
`default_nettype none

interface pfs_in_if import pfs_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_present;
    logic                       frame_last;

    modport source (output valid, output sample, output sample_present, output frame_last,
                    input ready);
    modport sink   (input valid, input sample, input sample_present, input frame_last,
                    output ready);

endinterface

`default_nettype wire

// ===== rtl/pfs_out_if.sv =====
// Handshake interface that carries one frame statistics item out of the block.
`default_nettype none

interface pfs_out_if import pfs_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [PEAK_W-1:0]   peak_abs;
    logic [CNT_W-1:0]    clip_total;
    logic [CNT_W-1:0]    zero_total;
    logic [ENERGY_W-1:0] energy_sum;

    modport source (output valid, output peak_abs, output clip_total, output zero_total,
                    output energy_sum, input ready);
    modport sink   (input valid, input peak_abs, input clip_total, input zero_total,
                    input energy_sum, output ready);

endinterface

`default_nettype wire

// ===== rtl/pcm_frame_statistics.sv =====
// Top level of the PCM frame statistics block: peak, clip, zero and energy per frame.
//
//   Channel  Direction  Payload                                         Handshake
//   i_in     sink       sample, sample_present, frame_last              valid/ready
//   o_out    source     peak_abs, clip_total, zero_total, energy_sum    valid/ready
//
// One item is accepted per cycle while the pipeline is not held; a frame's last item passes
// from the input register through the magnitude and square register to the result register.
// The stages are an input register, a magnitude and 16x16 square register, and the
// accumulate stage that loads the result register on the frame's last item.
// Reset clears the running figures and all valid flags.
// The whole pipeline holds only while a result waits in the output register and is not taken.
`default_nettype none

module pcm_frame_statistics import pfs_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pfs_in_if.sink      i_in,
    pfs_out_if.source   o_out
);

    logic en;

    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_a_sample;
    logic                       r_a_present;
    logic                       r_a_last;

    logic                r_b_valid;
    logic [PEAK_W-1:0]   r_b_mag;
    logic [SQ_W-1:0]     r_b_sq;
    logic                r_b_clip;
    logic                r_b_zero;
    logic                r_b_present;
    logic                r_b_last;

    logic [PEAK_W-1:0]   r_peak;
    logic [CNT_W-1:0]    r_clips;
    logic [CNT_W-1:0]    r_zeros;
    logic [ENERGY_W-1:0] r_energy;

    logic [PEAK_W-1:0]   n_peak;
    logic [CNT_W-1:0]    n_clips;
    logic [CNT_W-1:0]    n_zeros;
    logic [ENERGY_W-1:0] n_energy;

    logic                r_out_valid;
    logic [PEAK_W-1:0]   r_out_peak;
    logic [CNT_W-1:0]    r_out_clips;
    logic [CNT_W-1:0]    r_out_zeros;
    logic [ENERGY_W-1:0] r_out_energy;

    logic [PEAK_W-1:0]   a_mag;
    logic [SQ_W-1:0]     a_sq;
    logic                take;
    logic [ENERGY_W:0]   energy_add;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sample  <= i_in.sample;
            r_a_present <= i_in.sample_present;
            r_a_last    <= i_in.frame_last;
        end
    end

    // The magnitude of the most negative sample is 32768, which still fits 16 unsigned bits.
    always_comb begin
        a_mag = r_a_sample[SAMPLE_W-1] ? ($unsigned(~r_a_sample) + {{(PEAK_W-1){1'b0}}, 1'b1})
                                       : $unsigned(r_a_sample);
        a_sq  = {{(SQ_W-PEAK_W){1'b0}}, a_mag} * {{(SQ_W-PEAK_W){1'b0}}, a_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_mag     <= a_mag;
            r_b_sq      <= a_sq;
            r_b_clip    <= (r_a_sample == CLIP_HIGH) || (r_a_sample == CLIP_LOW);
            r_b_zero    <= (r_a_sample == '0);
            r_b_present <= r_a_present;
            r_b_last    <= r_a_last;
        end
    end

    always_comb begin
        take       = r_b_valid && r_b_present;
        energy_add = {1'b0, r_energy} + {{(ENERGY_W+1-SQ_W){1'b0}}, r_b_sq};

        n_peak   = r_peak;
        n_clips  = r_clips;
        n_zeros  = r_zeros;
        n_energy = r_energy;
        if (take) begin
            if (r_b_mag > r_peak) begin
                n_peak = r_b_mag;
            end
            if (r_b_clip && (r_clips != '1)) begin
                n_clips = r_clips + {{(CNT_W-1){1'b0}}, 1'b1};
            end
            if (r_b_zero && (r_zeros != '1)) begin
                n_zeros = r_zeros + {{(CNT_W-1){1'b0}}, 1'b1};
            end
            n_energy = energy_add[ENERGY_W] ? '1 : energy_add[ENERGY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_clips     <= '0;
            r_zeros     <= '0;
            r_energy    <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_b_valid && r_b_last;
            if (r_b_valid) begin
                if (r_b_last) begin
                    r_peak   <= '0;
                    r_clips  <= '0;
                    r_zeros  <= '0;
                    r_energy <= '0;
                end else begin
                    r_peak   <= n_peak;
                    r_clips  <= n_clips;
                    r_zeros  <= n_zeros;
                    r_energy <= n_energy;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_b_valid && r_b_last) begin
            r_out_peak   <= n_peak;
            r_out_clips  <= n_clips;
            r_out_zeros  <= n_zeros;
            r_out_energy <= n_energy;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.peak_abs   = r_out_peak;
    assign o_out.clip_total = r_out_clips;
    assign o_out.zero_total = r_out_zeros;
    assign o_out.energy_sum = r_out_energy;

endmodule

`default_nettype wire

// ===== rtl/pfs_checker.sv =====
// Port-level assertions for the PCM frame statistics block and the bind that attaches them.
`default_nettype none

module pfs_checker import pfs_pkg::*; (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [PEAK_W-1:0]   i_peak_abs,
    input wire [CNT_W-1:0]    i_clip_total,
    input wire [CNT_W-1:0]    i_zero_total,
    input wire [ENERGY_W-1:0] i_energy_sum
);

    // A result waiting for the sink keeps its valid and its whole payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_peak_abs)
            && $stable(i_clip_total) && $stable(i_zero_total) && $stable(i_energy_sum))
        else $error("result changed or dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_peak_abs <= PEAK_MAX)
        else $error("peak above full scale");

    // A frame whose peak is zero held only zero samples.
    a_silent_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_peak_abs == '0) |-> (i_energy_sum == '0) && (i_clip_total == '0))
        else $error("silent frame reports energy or clips");

    a_clip_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_clip_total != '0) |->
            (i_peak_abs == PEAK_MAX) || (i_peak_abs == PEAK_MAX - 16'd1))
        else $error("clipped samples without a full-scale peak");

endmodule

bind pcm_frame_statistics pfs_checker u_pfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_peak_abs   (o_out.peak_abs),
    .i_clip_total (o_out.clip_total),
    .i_zero_total (o_out.zero_total),
    .i_energy_sum (o_out.energy_sum)
);

`default_nettype wire

// ===== tb/sv/pfs_frame_checker.sv =====
// Checker that predicts the statistics of each frame from the accepted samples and compares them.
module pfs_frame_checker import pfs_pkg::*; (
    input  wire i_clk,
    input  wire i_rst_n,
    pfs_in_if   i_in,
    pfs_out_if  i_out,
    output int  o_fail_count,
    output int  o_waiting
);

    typedef struct packed {
        logic [PEAK_W-1:0]   peak_abs;
        logic [CNT_W-1:0]    clip_total;
        logic [CNT_W-1:0]    zero_total;
        logic [ENERGY_W-1:0] energy_sum;
    } frame_stats_t;

    frame_stats_t running;
    frame_stats_t stats_due[$];
    frame_stats_t want;

    function automatic frame_stats_t fold_sample(input frame_stats_t acc,
                                                 input logic signed [SAMPLE_W-1:0] s);
        int                  mag;
        logic [ENERGY_W:0]   wide_sum;
        frame_stats_t        nxt;
        nxt = acc;
        mag = (s < 0) ? -int'(s) : int'(s);
        if (mag > nxt.peak_abs) begin
            nxt.peak_abs = PEAK_W'(mag);
        end
        if ((s == CLIP_HIGH || s == CLIP_LOW) && nxt.clip_total != '1) begin
            nxt.clip_total = nxt.clip_total + 1'b1;
        end
        if (s == 0 && nxt.zero_total != '1) begin
            nxt.zero_total = nxt.zero_total + 1'b1;
        end
        wide_sum = {1'b0, nxt.energy_sum} + (ENERGY_W+1)'(mag) * (ENERGY_W+1)'(mag);
        nxt.energy_sum = wide_sum[ENERGY_W] ? '1 : wide_sum[ENERGY_W-1:0];
        return nxt;
    endfunction

    task automatic check_field(input string field, input logic [ENERGY_W-1:0] want_v,
                               input logic [ENERGY_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            running = '0;
            stats_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.sample_present) begin
                    running = fold_sample(running, i_in.sample);
                end
                if (i_in.frame_last) begin
                    stats_due.push_back(running);
                    running = '0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (stats_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got peak %0d energy %0d",
                             $time, i_out.peak_abs, i_out.energy_sum);
                    o_fail_count++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("peak_abs", want.peak_abs, i_out.peak_abs);
                    check_field("clip_total", want.clip_total, i_out.clip_total);
                    check_field("zero_total", want.zero_total, i_out.zero_total);
                    check_field("energy_sum", want.energy_sum, i_out.energy_sum);
                end
            end
        end
        o_waiting = stats_due.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench: drives frames of PCM samples into the block and gives the verdict.
module testbench;
    import pfs_pkg::*;

    localparam int ITEM_TARGET = 1650;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_took;
    int   fail_count;
    int   waiting;
    int   items_sent;
    int   burst_left;
    int   gap_max;
    int   stall_max;
    int   stall_left;

    pfs_in_if  in_ch ();
    pfs_out_if out_ch ();

    pcm_frame_statistics u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pfs_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        in_took <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (stall_max != 0 && $urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, stall_max);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return CLIP_HIGH;
            1: return CLIP_LOW;
            2: return '0;
            3: return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic drive_item(input logic signed [SAMPLE_W-1:0] s, input logic present,
                              input logic last);
        in_ch.valid          <= 1'b1;
        in_ch.sample         <= s;
        in_ch.sample_present <= present;
        in_ch.frame_last     <= last;
        do @(negedge i_clk); while (!in_took);
        if (present || last) begin
            items_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if (gap_max > 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("FAIL pcm_frame_statistics");
        $finish;
    end

    initial begin
        int frame_len;
        int drain_cycles;
        bit close_with_sample;

        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.sample         = '0;
        in_ch.sample_present = 1'b0;
        in_ch.frame_last     = 1'b0;
        out_ch.ready         = 1'b0;
        items_sent           = 0;
        burst_left           = 0;
        gap_max              = 3;
        stall_max            = 4;
        stall_left           = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames: empty closes, full scale of either sign, zeros and absent samples.
        drive_item('0, 1'b0, 1'b1);
        drive_item(CLIP_HIGH, 1'b1, 1'b0);
        drive_item(CLIP_LOW, 1'b1, 1'b0);
        drive_item(16'sh1234, 1'b0, 1'b0);
        drive_item('0, 1'b1, 1'b0);
        drive_item(16'sd1, 1'b1, 1'b0);
        drive_item(-16'sd1, 1'b1, 1'b1);
        drive_item(16'sh5555, 1'b1, 1'b0);
        drive_item(16'shAAAA, 1'b0, 1'b1);
        drive_item(CLIP_LOW, 1'b1, 1'b1);
        drive_item('0, 1'b1, 1'b1);
        drive_item(CLIP_HIGH, 1'b1, 1'b1);
        drive_item(16'shFFFF, 1'b0, 1'b1);
        drive_item('0, 1'b0, 1'b1);
        drive_item(16'shAAAA, 1'b1, 1'b0);
        drive_item(16'sh5555, 1'b1, 1'b0);
        drive_item(CLIP_LOW, 1'b1, 1'b0);
        drive_item(CLIP_LOW, 1'b1, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            case ((items_sent * 4) / ITEM_TARGET)
                0: begin gap_max = 0; stall_max = 0; end
                1: begin gap_max = 6; stall_max = 12; end
                2: begin gap_max = 4; stall_max = 0; end
                default: begin gap_max = 0; stall_max = 20; end
            endcase
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                     : $urandom_range(1, 16);
            if ($urandom_range(0, 19) == 0) begin
                frame_len = 0;
            end
            close_with_sample = (frame_len > 0) && ($urandom_range(0, 4) != 0);
            for (int k = 0; k < frame_len; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    drive_item(SAMPLE_W'($urandom()), 1'b0, 1'b0);
                end
                drive_item(pick_sample(), 1'b1, close_with_sample && k == frame_len - 1);
            end
            if (!close_with_sample) begin
                drive_item(SAMPLE_W'($urandom()), 1'b0, 1'b1);
            end
        end

        in_ch.valid <= 1'b0;
        stall_max = 0;
        drain_cycles = 0;
        while (waiting != 0 && drain_cycles < 5000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(negedge i_clk);

        if (fail_count == 0 && waiting == 0) begin
            $display("PASS pcm_frame_statistics");
        end else begin
            $display("FAIL pcm_frame_statistics");
        end
        $finish;
    end

endmodule
